### sv/double_add_sub_macros.svh
// assertion macros for the adder pipeline top module
// no dependencies
`ifndef DOUBLE_ADD_SUB_MACROS_SVH
`define DOUBLE_ADD_SUB_MACROS_SVH

// property holds on every clock edge outside reset
`define DAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication, consequent checked in the next cycle
`define DAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/das_pkg.sv
// types and constants for the binary64 add/subtract pipeline
// no dependencies
package das_pkg;

  localparam logic [10:0] ExpMax   = 11'h7ff;
  localparam logic [63:0] QnanBits = 64'h7ff8000000000000;

  // special-case result selected in the front stage
  typedef enum logic [1:0] {
    SP_NONE = 2'd0,
    SP_QNAN = 2'd1,
    SP_INF  = 2'd2
  } special_e;

  // aligned operands after swap and shift
  typedef struct packed {
    special_e    special;
    logic        sign;
    logic        eff_sub;
    logic        both_sign;
    logic [10:0] exp;
    logic [63:0] ma;
    logic [63:0] mb;
  } align_t;

  // raw sum before normalization
  typedef struct packed {
    special_e    special;
    logic        sign;
    logic        zero_sign;
    logic [11:0] exp;
    logic [63:0] r;
  } sum_t;

  // normalized value before rounding
  typedef struct packed {
    special_e    special;
    logic        sign;
    logic        zero_sign;
    logic        is_zero;
    logic [11:0] exp;
    logic [63:0] r;
  } norm_t;

endpackage

### sv/double_add_sub.sv
// binary64 add/subtract, round to nearest even, subnormals kept, canonical nan
// stages in order: align, add, normalize, round
// throughput: one request per cycle; a full stage holds while its successor is stalled
// reset: valid bits of all four stages clear asynchronously; payload registers are not reset
// depends on das_pkg, das_align, das_norm, das_round and double_add_sub_macros.svh
`include "double_add_sub_macros.svh"
module double_add_sub (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        action_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] sum_bits_o
);
  import das_pkg::*;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        en1, en2, en3, en4;
  align_t      align_d, align_q;
  sum_t        sum_d, sum_q;
  norm_t       norm_d, norm_q;
  logic [63:0] res_d, res_q;

  // each stage advances when its successor is empty or moving
  assign en4 = !v4_q || ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  das_align u_align (
    .action_i   (action_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .align_o    (align_d)
  );

  always_comb begin
    sum_d.special   = align_q.special;
    sum_d.sign      = align_q.sign;
    sum_d.zero_sign = align_q.eff_sub ? 1'b0 : align_q.both_sign;
    sum_d.exp       = {1'b0, align_q.exp};
    sum_d.r         = align_q.eff_sub ? align_q.ma - align_q.mb : align_q.ma + align_q.mb;
  end

  das_norm u_norm (
    .sum_i (sum_q),
    .norm_o(norm_d)
  );

  das_round u_round (
    .norm_i    (norm_q),
    .sum_bits_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) align_q <= align_d;
    if (en2 && v1_q)    sum_q   <= sum_d;
    if (en3 && v2_q)    norm_q  <= norm_d;
    if (en4 && v3_q)    res_q   <= res_d;
  end

  assign valid_o    = v4_q;
  assign sum_bits_o = res_q;

  `DAS_ASSERT(a_stall_hold, (v4_q && !ready_i) |=> (v4_q && $stable(res_q)), "result lost on stall")
  `DAS_ASSERT_NEXT(a_ready_when_drained, !v1_q && !v2_q && !v3_q && !v4_q, ready_o, "empty pipe not ready")
  `DAS_ASSERT_NEXT(a_advance, v3_q && ready_i, v4_q, "stage three request dropped")
endmodule

### sv/das_align.sv
// front stage logic: classify, order by magnitude, align the smaller operand
// depends on das_pkg
module das_align (
  input  logic                   action_i,
  input  logic [63:0]            operand_a_i,
  input  logic [63:0]            operand_b_i,
  output das_pkg::align_t        align_o
);
  import das_pkg::*;

  logic        sa, sb, s_hi, s_lo;
  logic [10:0] ea, eb, ea1, eb1, e_hi, e_lo, d;
  logic [51:0] fa, fb;
  logic [63:0] ma, mb, m_hi, m_lo, sh, lost_mask;
  logic        nan_a, nan_b, inf_a, inf_b, swap;

  always_comb begin
    sa = operand_a_i[63];
    sb = operand_b_i[63] ^ action_i;
    ea = operand_a_i[62:52];
    eb = operand_b_i[62:52];
    fa = operand_a_i[51:0];
    fb = operand_b_i[51:0];
    nan_a = (ea == ExpMax) && (fa != '0);
    nan_b = (eb == ExpMax) && (fb != '0);
    inf_a = (ea == ExpMax) && (fa == '0);
    inf_b = (eb == ExpMax) && (fb == '0);
    ma = {1'b0, (ea != '0), fa, 10'd0};
    mb = {1'b0, (eb != '0), fb, 10'd0};
    ea1 = (ea == '0) ? 11'd1 : ea;
    eb1 = (eb == '0) ? 11'd1 : eb;
    swap = (eb1 > ea1) || ((eb1 == ea1) && (mb > ma));
    m_hi = swap ? mb : ma;
    m_lo = swap ? ma : mb;
    s_hi = swap ? sb : sa;
    s_lo = swap ? sa : sb;
    e_hi = swap ? eb1 : ea1;
    e_lo = swap ? ea1 : eb1;
    d = e_hi - e_lo;
    lost_mask = '0;
    if (d >= 11'd63) begin
      sh = {63'd0, (m_lo != '0)};
    end else begin
      lost_mask = ~(64'hffffffffffffffff << d[5:0]);
      sh = (m_lo >> d[5:0]) | {63'd0, ((m_lo & lost_mask) != '0)};
    end

    align_o.ma        = m_hi;
    align_o.mb        = sh;
    align_o.sign      = s_hi;
    align_o.eff_sub   = s_hi ^ s_lo;
    align_o.both_sign = sa;
    align_o.exp       = e_hi;
    if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
      align_o.special = SP_QNAN;
    end else if (inf_a || inf_b) begin
      align_o.special = SP_INF;
      align_o.sign    = inf_a ? sa : sb;
    end else begin
      align_o.special = SP_NONE;
    end
  end
endmodule

### sv/das_norm.sv
// normalization stage logic: leading-one shift bounded by the exponent
// depends on das_pkg
module das_norm (
  input  das_pkg::sum_t  sum_i,
  output das_pkg::norm_t norm_o
);
  import das_pkg::*;

  logic [63:0] r1;
  logic [11:0] e1;
  logic [5:0]  lz;
  logic [11:0] sh;
  logic        found;

  always_comb begin
    r1 = sum_i.r;
    e1 = sum_i.exp;
    if (sum_i.r[63]) begin
      r1 = {1'b0, sum_i.r[63:2], sum_i.r[1] | sum_i.r[0]};
      e1 = sum_i.exp + 12'd1;
    end
    // count zeros above the leading one, counting from bit 62
    lz = 6'd62;
    found = 1'b0;
    for (int i = 62; i >= 0; i--) begin
      if (!found && r1[i]) begin
        lz = 6'(62 - i);
        found = 1'b1;
      end
    end
    sh = (e1 - 12'd1 < {6'd0, lz}) ? e1 - 12'd1 : {6'd0, lz};
    norm_o.r         = r1 << sh[5:0];
    norm_o.exp       = e1 - sh;
    norm_o.special   = sum_i.special;
    norm_o.sign      = sum_i.sign;
    norm_o.zero_sign = sum_i.zero_sign;
    norm_o.is_zero   = (sum_i.r == '0);
  end
endmodule

### sv/das_round.sv
// rounding and packing stage logic: nearest even, overflow to infinity
// depends on das_pkg
module das_round (
  input  das_pkg::norm_t norm_i,
  output logic [63:0]    sum_bits_o
);
  import das_pkg::*;

  logic [53:0] mant;
  logic [9:0]  rem;
  logic [11:0] e;
  logic        up;

  always_comb begin
    mant = {1'b0, norm_i.r[62:10]};
    rem  = norm_i.r[9:0];
    e    = norm_i.exp;
    up   = (rem > 10'h200) || ((rem == 10'h200) && mant[0]);
    mant = mant + {53'd0, up};
    if (mant[53]) begin
      mant = mant >> 1;
      e    = e + 12'd1;
    end
    unique case (norm_i.special)
      SP_QNAN: sum_bits_o = QnanBits;
      SP_INF:  sum_bits_o = {norm_i.sign, ExpMax, 52'd0};
      default: begin
        if (norm_i.is_zero) begin
          sum_bits_o = {norm_i.zero_sign, 63'd0};
        end else if (e >= {1'b0, ExpMax}) begin
          sum_bits_o = {norm_i.sign, ExpMax, 52'd0};
        end else begin
          sum_bits_o = {norm_i.sign, (mant[52] ? e[10:0] : 11'd0), mant[51:0]};
        end
      end
    endcase
  end
endmodule

### tb/tb_double_add_sub.sv
// testbench for double_add_sub: binary64 add/subtract, checked against its own predictor
// depends on the double_add_sub rtl and das_pkg (canonical nan constant)
`timescale 1ns / 1ps
module tb_double_add_sub;
  import das_pkg::*;

  localparam logic [63:0] FracMask  = 64'h000fffffffffffff;
  localparam logic [63:0] HiddenBit = 64'h0010000000000000;
  localparam logic [63:0] PosInf    = 64'h7ff0000000000000;
  localparam logic [63:0] NegInf    = 64'hfff0000000000000;
  localparam logic [63:0] NegZero   = 64'h8000000000000000;
  localparam logic [63:0] MaxFin    = 64'h7fefffffffffffff;
  localparam logic [63:0] MinSub    = 64'h0000000000000001;
  localparam logic [63:0] NoCheck   = 64'hdeadbeefdeadbeef;  // row uses predictor
  localparam int          Guard     = 10;

  typedef enum logic {ACT_ADD = 1'b0, ACT_SUB = 1'b1} action_e;

  typedef struct {
    action_e     act;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic        action_i = 1'b0;
  logic [63:0] operand_a_i = '0;
  logic [63:0] operand_b_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [63:0] sum_bits_o;

  logic [63:0] sum_queue[$];
  int          mismatches = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;     // no idling near the end
  bit          hold_off = 1'b0; // long receiver stall

  double_add_sub dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] pack_fp(logic s, logic [10:0] e, logic [63:0] f);
    return {s, e, f[51:0]};
  endfunction

  function automatic logic [63:0] fp_add(logic [63:0] a, logic [63:0] b);
    logic        sa, sb, ts, sign;
    logic [10:0] ea, eb;
    logic [11:0] ex, te, d;
    logic [63:0] fa, fb, ma, mb, r, mant, rem, t, lost;
    sa = a[63]; sb = b[63];
    ea = a[62:52]; eb = b[62:52];
    fa = a & FracMask; fb = b & FracMask;
    if ((ea == ExpMax && fa != 0) || (eb == ExpMax && fb != 0)) return QnanBits;
    if (ea == ExpMax && eb == ExpMax) return (sa == sb) ? pack_fp(sa, ExpMax, 0) : QnanBits;
    if (ea == ExpMax) return pack_fp(sa, ExpMax, 0);
    if (eb == ExpMax) return pack_fp(sb, ExpMax, 0);
    ma = (fa | (ea != 0 ? HiddenBit : 64'd0)) << Guard;
    mb = (fb | (eb != 0 ? HiddenBit : 64'd0)) << Guard;
    ex = (ea == 0) ? 12'd1 : {1'b0, ea};
    te = (eb == 0) ? 12'd1 : {1'b0, eb};
    if (te > ex || (te == ex && mb > ma)) begin
      t = ma; ma = mb; mb = t;
      ts = sa; sa = sb; sb = ts;
      d = ex; ex = te; te = d;
    end
    d = ex - te;
    if (d >= 63) begin
      mb = (mb != 0) ? 64'd1 : 64'd0;
    end else if (d > 0) begin
      lost = mb & ((64'd1 << d) - 1);
      mb = (mb >> d) | ((lost != 0) ? 64'd1 : 64'd0);
    end
    r = (sa == sb) ? ma + mb : ma - mb;
    sign = sa;
    if (r == 0) return pack_fp((sa == sb) ? sa : 1'b0, 0, 0);
    if (r[63]) begin
      r = (r >> 1) | (r & 1);
      ex++;
    end
    while (!r[62] && ex > 1) begin
      r <<= 1;
      ex--;
    end
    mant = r >> Guard;
    rem = r & ((64'd1 << Guard) - 1);
    if (rem > (64'd1 << (Guard - 1)) || (rem == (64'd1 << (Guard - 1)) && mant[0])) mant++;
    if (mant[53]) begin
      mant >>= 1;
      ex++;
    end
    if (ex >= 12'h7ff) return pack_fp(sign, ExpMax, 0);
    return pack_fp(sign, (mant & HiddenBit) != 0 ? ex[10:0] : 11'd0, mant);
  endfunction

  // random operand biased toward interesting exponents
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v[62:52] = 11'h000;
      1: v[62:52] = 11'h7ff;
      2: v[62:52] = 11'h7fe - 11'($urandom_range(0, 3));
      3: v[62:52] = 11'($urandom_range(0, 3));
      4: v[51:0] = $urandom_range(0, 1) ? 52'd0 : {52{1'b1}};
      default: ;
    endcase
    return v;
  endfunction

  // sender gap: valid drops only when a gap follows
  task automatic idle_burst();
    if (!calm && $urandom_range(0, 5) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic send_request(action_e act, logic [63:0] a, logic [63:0] b);
    idle_burst();
    valid_i <= 1'b1;
    action_i <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    sum_queue.push_back(fp_add(a, act == ACT_SUB ? {~b[63], b[62:0]} : b));
    do @(posedge clk_i); while (!ready_o);
  endtask

  // receiver with random stall bursts and one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) begin
      ready_i <= 1'b0;
    end else if (calm) begin
      ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      ready_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 7);
      ready_i <= 1'b0;
    end else begin
      ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) begin
      if (sum_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, sum_bits_o);
        mismatches++;
      end else begin
        if (sum_bits_o !== sum_queue[0]) begin
          $display("%0t: sum_bits expected %h actual %h", $time, sum_queue[0], sum_bits_o);
          mismatches++;
        end
        void'(sum_queue.pop_front());
      end
    end
  end

  initial begin
    row_t rows[$];
    int   n;
    int   table_errs;
    table_errs = 0;
    rows = '{
      '{ACT_ADD, 64'h0, 64'h0, 64'h0},
      '{ACT_ADD, NegZero, NegZero, NegZero},
      '{ACT_SUB, NegZero, 64'h0, NegZero},
      '{ACT_SUB, 64'h3ff0000000000000, 64'h3ff0000000000000, 64'h0},
      '{ACT_ADD, 64'h7ff0000000000001, 64'h0, QnanBits},
      '{ACT_SUB, 64'hfff8000000000123, 64'h3ff0000000000000, QnanBits},
      '{ACT_ADD, PosInf, NegInf, QnanBits},
      '{ACT_SUB, PosInf, PosInf, QnanBits},
      '{ACT_ADD, PosInf, PosInf, PosInf},
      '{ACT_SUB, 64'h3ff0000000000000, PosInf, NegInf},
      '{ACT_ADD, NegInf, MaxFin, NegInf},
      '{ACT_ADD, MaxFin, MaxFin, PosInf},
      '{ACT_SUB, {1'b1, MaxFin[62:0]}, MaxFin, NegInf},
      '{ACT_ADD, MinSub, MinSub, 64'h2},
      '{ACT_SUB, MinSub, MinSub, 64'h0},
      '{ACT_ADD, 64'h000fffffffffffff, MinSub, 64'h0010000000000000},
      '{ACT_ADD, 64'h3ff0000000000000, 64'h3ca0000000000000, NoCheck},
      '{ACT_ADD, 64'h3ff0000000000001, 64'h3ca0000000000000, NoCheck},
      '{ACT_SUB, 64'h3ff0000000000000, 64'h3fefffffffffffff, NoCheck},
      '{ACT_ADD, 64'hffffffffffffffff, 64'hffffffffffffffff, QnanBits},
      '{ACT_ADD, 64'h3ff0000000000000, MinSub, NoCheck},
      '{ACT_SUB, 64'h4340000000000000, 64'hbff8000000000000, NoCheck}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      if (rows[i].want != NoCheck &&
          fp_add(rows[i].a, rows[i].act == ACT_SUB ? {~rows[i].b[63], rows[i].b[62:0]}
                                                    : rows[i].b) !== rows[i].want) begin
        $display("%0t: table row %0d expected %h actual %h", $time, i, rows[i].want,
                 fp_add(rows[i].a, rows[i].act == ACT_SUB ?
                        {~rows[i].b[63], rows[i].b[62:0]} : rows[i].b));
        table_errs++;
      end
      send_request(rows[i].act, rows[i].a, rows[i].b);
    end
    n = 0;
    repeat (1400) begin
      logic [63:0] a, b;
      a = rand_operand();
      b = rand_operand();
      // near-cancellation and close exponents
      if ($urandom_range(0, 3) == 0) b = {$urandom_range(0, 1) ? ~a[63] : a[63], a[62:0]} ^
                                         ($urandom_range(0, 1) ? 64'd0 : 64'(1 << $urandom_range(0, 20)));
      n++;
      if (n == 300) hold_off <= 1'b1;
      if (n == 1200) calm <= 1'b1;
      send_request(action_e'($urandom_range(0, 1)), a, b);
    end
    valid_i <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && table_errs == 0) $display("tb_double_add_sub: clean");
    else $display("tb_double_add_sub: errors");
    $finish;
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (hold_off);
    repeat (40) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("tb_double_add_sub: errors");
    $finish;
  end
endmodule
